FILE: rtl/bffa_pkg.sv
`timescale 1ns / 1ps

package bffa_pkg;

  // Heap geometry.
  localparam int NUM_BLOCKS  = 64;
  localparam int BLOCK_BYTES = 1024;
  localparam int BB_LOG      = $clog2(BLOCK_BYTES);

  // Field widths.
  localparam int ADDR_W  = 32;
  localparam int BYTES_W = 17;
  localparam int START_W = 6;

  // Derived widths for block indexes, block counts and run ends.
  localparam int IDX_W  = $clog2(NUM_BLOCKS);
  localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
  localparam int NEED_W = BYTES_W + 1 - BB_LOG;
  localparam int END_W  = ((NEED_W > CNT_W) ? NEED_W : CNT_W) + 1;

  // Size of the managed region in bytes, one bit wider than an address.
  localparam logic [ADDR_W:0] HEAP_BYTES = (ADDR_W + 1)'(NUM_BLOCKS * BLOCK_BYTES);

  // Operation codes of an input item.
  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  // Control shared by every cell of the map row.
  typedef struct packed {
    logic             shift;
    logic             set_en;
    logic             set_val;
    logic [IDX_W-1:0] lo;
    logic [END_W-1:0] hi;
  } cell_ctrl_t;

endpackage

FILE: rtl/bitmap_first_fit_block_allocator_core.sv
`timescale 1ns / 1ps
// Allocate: the 64-cell block map rotates one full turn past the run counter, then the
// result is committed to the output register once that register can take it.
// A request for more blocks than the heap holds, and any free, skip the rotation and go
// straight to the commit. One item is in work at a time; the next is taken the cycle after
// a result is committed.
// Reset clears every map cell at once (all blocks free) and sets heap_base to zero.
module bitmap_first_fit_block_allocator_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            heap_base_we_i,
  input  logic [bffa_pkg::ADDR_W-1:0]     heap_base_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            cmd_i,
  input  logic [bffa_pkg::BYTES_W-1:0]    byte_count_i,
  input  logic [bffa_pkg::ADDR_W-1:0]     free_address_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bffa_pkg::ADDR_W-1:0]     alloc_address_o,
  output logic [bffa_pkg::START_W-1:0]    start_block_o,
  output logic                            failed_o
);
  import bffa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [ADDR_W-1:0] heap_base_q;
  logic              op_q;
  logic [NEED_W-1:0] need_q;
  logic [CNT_W-1:0]  run_q;
  logic [IDX_W-1:0]  cnt_q;
  logic              found_q;
  logic              fail_q;
  logic [IDX_W-1:0]  lo_q;
  logic [END_W-1:0]  hi_q;

  logic              out_valid_q;
  logic [ADDR_W-1:0] alloc_address_q;
  logic [START_W-1:0] start_block_q;
  logic              failed_q;

  logic              in_acc;
  logic              commit;
  logic [BYTES_W:0]  byte_sum;
  logic [NEED_W-1:0] need_raw;
  logic [NEED_W-1:0] need_c;
  logic              too_big;
  logic [ADDR_W-1:0] off;
  logic              outside;
  logic [IDX_W-1:0]  free_lo;
  logic [CNT_W-1:0]  run_nx;
  logic              hit;
  logic              last;

  logic [NUM_BLOCKS-1:0] taken;
  cell_ctrl_t            ctrl;

  // Handshake.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign commit     = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  // Block count of the request: rounded up, at least one.
  assign byte_sum = {1'b0, byte_count_i} + (BYTES_W + 1)'(BLOCK_BYTES - 1);
  assign need_raw = NEED_W'(byte_sum >> BB_LOG);
  assign need_c   = (need_raw == '0) ? NEED_W'(1) : need_raw;
  assign too_big  = (END_W'(need_c) > END_W'(NUM_BLOCKS));

  // Free address check and its block index.
  assign off     = free_address_i - heap_base_q;
  assign outside = (free_address_i < heap_base_q) || ({1'b0, off} >= HEAP_BYTES);
  assign free_lo = IDX_W'(off >> BB_LOG);

  // Run counter fed by the bit that sits at the head of the rotating map.
  assign run_nx = taken[0] ? '0 : (run_q + CNT_W'(1));
  assign hit    = !found_q && (END_W'(run_nx) == END_W'(need_q));
  assign last   = (cnt_q == IDX_W'(NUM_BLOCKS - 1));

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= '0;
    end else if (heap_base_we_i) begin
      heap_base_q <= heap_base_i;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (cmd_i == CMD_ALLOC && !too_big) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_SCAN: begin
        if (last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      found_q <= 1'b0;
      cnt_q   <= '0;
      run_q   <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        found_q <= 1'b0;
        cnt_q   <= '0;
        run_q   <= '0;
      end else if (state_q == ST_SCAN) begin
        run_q <= run_nx;
        cnt_q <= cnt_q + IDX_W'(1);
        if (hit) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  // Item registers: operation, block count and the run bounds.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= cmd_i;
      need_q <= need_c;
      if (cmd_i == CMD_ALLOC) begin
        fail_q <= too_big;
      end else begin
        fail_q <= outside;
        lo_q   <= free_lo;
        hi_q   <= END_W'(free_lo) + END_W'(need_c);
      end
    end else if (state_q == ST_SCAN) begin
      if (hit) begin
        lo_q <= IDX_W'(END_W'(cnt_q) + END_W'(1) - END_W'(need_q));
        hi_q <= END_W'(cnt_q) + END_W'(1);
      end
      if (last) begin
        fail_q <= !(found_q || hit);
      end
    end
  end

  // Map row: cell j takes the bit of cell j+1 while rotating, the last takes cell 0.
  always_comb begin
    ctrl.shift   = (state_q == ST_SCAN);
    ctrl.set_en  = commit && !fail_q;
    ctrl.set_val = (op_q == CMD_ALLOC);
    ctrl.lo      = lo_q;
    ctrl.hi      = hi_q;
  end

  for (genvar j = 0; j < NUM_BLOCKS; j++) begin : g_cell
    bffa_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .idx_i      (IDX_W'(j)),
      .neighbor_i (taken[(j + 1) % NUM_BLOCKS]),
      .taken_o    (taken[j])
    );
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      failed_q <= fail_q;
      if (fail_q) begin
        alloc_address_q <= '0;
        start_block_q   <= '0;
      end else begin
        start_block_q <= START_W'(lo_q);
        if (op_q == CMD_ALLOC) begin
          alloc_address_q <= heap_base_q + (ADDR_W'(lo_q) << BB_LOG);
        end else begin
          alloc_address_q <= '0;
        end
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign alloc_address_o = alloc_address_q;
  assign start_block_o   = start_block_q;
  assign failed_o        = failed_q;

  // A new scan always starts from the head of the map with an empty run.
  a_scan_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_SCAN) |-> (cnt_q == '0 && run_q == '0))
    else $error("scan started with stale counters");

  // A failed item leaves the map untouched.
  a_fail_keeps_map : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && fail_q) |=> $stable(taken))
    else $error("map changed on a failed item");

  // A found run ends inside the map.
  a_run_in_map : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && !fail_q && op_q == CMD_ALLOC) |-> (hi_q <= END_W'(NUM_BLOCKS)))
    else $error("allocated run past the map end");

  // A failed result carries zero address and start block.
  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && failed_o) |-> (alloc_address_o == '0 && start_block_o == '0))
    else $error("failed item with nonzero fields");

endmodule

FILE: rtl/bffa_cell.sv
`timescale 1ns / 1ps

module bffa_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bffa_pkg::cell_ctrl_t    ctrl_i,
  input  logic [bffa_pkg::IDX_W-1:0] idx_i,
  input  logic                    neighbor_i,
  output logic                    taken_o
);
  import bffa_pkg::*;

  logic taken_q;
  logic taken_d;
  logic in_range;

  // A cell belongs to the run when its position lies in [lo, hi).
  assign in_range = (idx_i >= ctrl_i.lo) && (END_W'(idx_i) < ctrl_i.hi);

  // Rotate during a scan, otherwise take a mark or a release for the run.
  always_comb begin
    taken_d = taken_q;
    if (ctrl_i.shift) begin
      taken_d = neighbor_i;
    end else if (ctrl_i.set_en && in_range) begin
      taken_d = ctrl_i.set_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= 1'b0;
    end else begin
      taken_q <= taken_d;
    end
  end

  assign taken_o = taken_q;

endmodule

FILE: dv/bitmap_alloc_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the heap_base port, keeps its own copy of the
// block map, predicts every reply and compares it with what the core returns.
module bitmap_alloc_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         heap_base_we_i,
  input  logic [bffa_pkg::ADDR_W-1:0]  heap_base_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         cmd_i,
  input  logic [bffa_pkg::BYTES_W-1:0] byte_count_i,
  input  logic [bffa_pkg::ADDR_W-1:0]  free_address_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [bffa_pkg::ADDR_W-1:0]  alloc_address_i,
  input  logic [bffa_pkg::START_W-1:0] start_block_i,
  input  logic                         failed_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           checked_o,
  output int                           placed_o,
  output int                           flagged_o
);
  import bffa_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0]  alloc_address;
    logic [START_W-1:0] start_block;
    logic               failed;
  } reply_t;

  logic [NUM_BLOCKS-1:0] taken_map;
  logic [ADDR_W-1:0]     heap_base_q;
  reply_t                predicted_replies_q[$];

  // Applies one request to the shadow map and returns the reply it should give.
  function automatic reply_t apply_request(cmd_e cmd, logic [BYTES_W-1:0] bytes,
                                           logic [ADDR_W-1:0] addr);
    reply_t          r;
    int              need;
    int              run;
    int              first;
    bit              found;
    logic [ADDR_W:0] offset;
    r     = '0;
    run   = 0;
    first = 0;
    found = 1'b0;
    // Zero bytes still takes one block.
    need = (int'(bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
    if (need == 0) need = 1;
    if (cmd == CMD_ALLOC) begin
      // First fit: the lowest run of free blocks long enough.
      if (need <= NUM_BLOCKS) begin
        for (int i = 0; i < NUM_BLOCKS; i++) begin
          if (!found) begin
            run = taken_map[i] ? 0 : run + 1;
            if (run == need) begin
              first = i + 1 - need;
              found = 1'b1;
            end
          end
        end
      end
      if (found) begin
        for (int i = first; i < first + need; i++) taken_map[i] = 1'b1;
        r.alloc_address = heap_base_q + ADDR_W'(first * BLOCK_BYTES);
        r.start_block   = START_W'(first);
      end else begin
        r.failed = 1'b1;
      end
    end else begin
      // A free must land inside the heap; blocks past the map end are dropped.
      offset = {1'b0, addr} - {1'b0, heap_base_q};
      if (addr < heap_base_q || offset >= HEAP_BYTES) begin
        r.failed = 1'b1;
      end else begin
        first = int'(offset) / BLOCK_BYTES;
        for (int i = first; i < first + need && i < NUM_BLOCKS; i++) taken_map[i] = 1'b0;
        r.start_block = START_W'(first);
      end
    end
    return r;
  endfunction

  // Replies are checked before new items are predicted in the same cycle.
  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    reply_t want;
    reply_t got;
    if (!rst_ni) begin
      taken_map    = '0;
      heap_base_q  = '0;
      predicted_replies_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
      checked_o    = 0;
      placed_o     = 0;
      flagged_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{alloc_address_i, start_block_i, failed_i};
        if (predicted_replies_q.size() == 0) begin
          $display("%0t: reply with none expected: addr %h start %0d failed %0b",
                   $time, got.alloc_address, got.start_block, got.failed);
          fail_count_o++;
        end else begin
          want = predicted_replies_q.pop_front();
          checked_o++;
          if (got.alloc_address !== want.alloc_address) begin
            $display("%0t: alloc_address mismatch: expected %h, actual %h",
                     $time, want.alloc_address, got.alloc_address);
            fail_count_o++;
          end
          if (got.start_block !== want.start_block) begin
            $display("%0t: start_block mismatch: expected %0d, actual %0d",
                     $time, want.start_block, got.start_block);
            fail_count_o++;
          end
          if (got.failed !== want.failed) begin
            $display("%0t: failed mismatch: expected %0b, actual %0b",
                     $time, want.failed, got.failed);
            fail_count_o++;
          end
        end
      end
      if (heap_base_we_i) heap_base_q = heap_base_i;
      if (in_valid_i && !in_stall_i) begin
        want = apply_request(cmd_e'(cmd_i), byte_count_i, free_address_i);
        if (want.failed) flagged_o++;
        else if (cmd_e'(cmd_i) == CMD_ALLOC) placed_o++;
        predicted_replies_q.push_back(want);
      end
      pending_o = predicted_replies_q.size();
    end
  end

endmodule

FILE: dv/bitmap_first_fit_block_allocator_core_tb.sv
`timescale 1ns / 1ps

module bitmap_first_fit_block_allocator_core_tb;
  import bffa_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 136;
  localparam int DRAIN_CYCLES = 80;

  logic               clk_i;
  logic               rst_ni;
  logic               heap_base_we_i;
  logic [ADDR_W-1:0]  heap_base_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               cmd_i;
  logic [BYTES_W-1:0] byte_count_i;
  logic [ADDR_W-1:0]  free_address_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [ADDR_W-1:0]  alloc_address_o;
  logic [START_W-1:0] start_block_o;
  logic               failed_o;

  int fail_count;
  int pending;
  int checked;
  int placed;
  int flagged;
  int items_sent = 0;
  int cycle_count;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  bitmap_first_fit_block_allocator_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .heap_base_we_i (heap_base_we_i),
    .heap_base_i    (heap_base_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .byte_count_i   (byte_count_i),
    .free_address_i (free_address_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .alloc_address_o(alloc_address_o),
    .start_block_o  (start_block_o),
    .failed_o       (failed_o)
  );

  bitmap_alloc_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .heap_base_we_i (heap_base_we_i),
    .heap_base_i    (heap_base_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .cmd_i          (cmd_i),
    .byte_count_i   (byte_count_i),
    .free_address_i (free_address_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .alloc_address_i(alloc_address_o),
    .start_block_i  (start_block_o),
    .failed_i       (failed_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .placed_o       (placed),
    .flagged_o      (flagged)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Reply side: random stalls, plus one long hold-off on request.
  initial begin : reply_sink
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < 38);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Offers one item, with an occasional gap first, and waits until it is taken.
  task automatic send_item(cmd_e c, logic [BYTES_W-1:0] bytes, logic [ADDR_W-1:0] addr);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 99) < 38) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= c;
    byte_count_i   <= bytes;
    free_address_i <= addr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Stops offering items until every predicted reply has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_heap_base(logic [ADDR_W-1:0] base);
    wait_drained();
    heap_base_we_i <= 1'b1;
    heap_base_i    <= base;
    @(negedge clk_i);
    heap_base_we_i <= 1'b0;
  endtask

  // One heap base setting with a random mix of allocations and frees.
  task automatic run_phase(logic [ADDR_W-1:0] base, int phase);
    int                 r;
    cmd_e               c;
    logic [BYTES_W-1:0] bytes;
    logic [ADDR_W-1:0]  addr;
    write_heap_base(base);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (phase == 3) calm = (i < 70);
      if (phase == 1 && i == 30) hold_req = 1'b1;
      if (phase == 2 && i == 60) wait_drained();
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 55) begin
        c    = CMD_ALLOC;
        addr = $urandom;
        if (r < 5) bytes = '0;
        else if (r < 12) bytes = BYTES_W'($urandom_range(0, 131071));
        else if (r < 18) bytes = BYTES_W'($urandom_range(16385, 65536));
        else bytes = BYTES_W'($urandom_range(1, 6144));
      end else begin
        c     = CMD_FREE;
        bytes = (r < 10) ? BYTES_W'($urandom_range(0, 131071))
                         : BYTES_W'($urandom_range(0, 8192));
        r     = $urandom_range(0, 99);
        if (r < 8) addr = $urandom;
        else if (r < 14) addr = base - ADDR_W'($urandom_range(1, 65536));
        else if (r < 20) addr = base + 32'h0001_0000 + ADDR_W'($urandom_range(0, 4095));
        else addr = base + ADDR_W'($urandom_range(0, NUM_BLOCKS - 1) * BLOCK_BYTES)
                         + ADDR_W'($urandom_range(0, BLOCK_BYTES - 1));
      end
      send_item(c, bytes, addr);
    end
    calm = 1'b0;
  endtask

  initial begin : stimulus
    rst_ni         = 1'b0;
    heap_base_we_i = 1'b0;
    heap_base_i    = '0;
    in_valid_i     = 1'b0;
    cmd_i          = CMD_ALLOC;
    byte_count_i   = '0;
    free_address_i = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed items with the heap at address zero after reset.
    send_item(CMD_ALLOC, 17'd0, $urandom);
    send_item(CMD_ALLOC, 17'd1, $urandom);
    send_item(CMD_ALLOC, 17'd1024, $urandom);
    send_item(CMD_ALLOC, 17'd1025, $urandom);
    send_item(CMD_ALLOC, 17'd65536, $urandom);
    send_item(CMD_ALLOC, 17'h1FFFF, $urandom);
    send_item(CMD_FREE, 17'd0, 32'd100);
    send_item(CMD_FREE, 17'd2048, 32'd3072);
    send_item(CMD_ALLOC, 17'd2048, $urandom);
    send_item(CMD_FREE, 17'd0, 32'h0001_0000);
    send_item(CMD_FREE, 17'd0, 32'hFFFF_FFFF);
    send_item(CMD_FREE, 17'h1FFFF, 32'd64517);
    send_item(CMD_FREE, 17'd1024, 32'd10240);
    send_item(CMD_FREE, 17'd65536, 32'd0);
    send_item(CMD_ALLOC, 17'd65536, $urandom);
    send_item(CMD_ALLOC, 17'd0, $urandom);
    send_item(CMD_FREE, 17'd65536, 32'h0000_FFFF);
    send_item(CMD_ALLOC, 17'd1, $urandom);
    send_item(CMD_FREE, 17'd65536, 32'd0);

    // A free just below the heap, then an unaligned free inside it.
    write_heap_base(32'h8000_0000);
    send_item(CMD_FREE, 17'd0, 32'h7FFF_FFFF);
    send_item(CMD_ALLOC, 17'd1, $urandom);
    send_item(CMD_FREE, 17'd1, 32'h8000_03FF);

    // Allocation addresses that wrap past the top of the address space.
    write_heap_base(32'hFFFF_8000);
    send_item(CMD_ALLOC, 17'd40960, $urandom);
    send_item(CMD_ALLOC, 17'd10240, $urandom);
    send_item(CMD_FREE, 17'd65536, 32'hFFFF_8000);

    // Random phases over several heap bases, extremes included.
    run_phase(32'hFFFF_FFFF, 0);
    run_phase(32'h0001_0000, 1);
    run_phase($urandom, 2);
    run_phase(32'hFFFF_0000, 3);
    run_phase(32'h0000_0000, 4);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d items and checked %0d replies over seven heap base settings.",
             items_sent, checked);
    $display("Of these, %0d allocations were placed and %0d requests were flagged as failed.",
             placed, flagged);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
